// File: rtl/core/bis_pkg.sv
// ----------------------------------------------------------------------------
// bis_pkg
// Types and constants shared by the bounded integer set store.
// ----------------------------------------------------------------------------
package bis_pkg;

	localparam int CAPACITY_DEF = 128;

	typedef enum logic [0:0] {
		REQ_INSERT = 1'b0,
		REQ_REMOVE = 1'b1
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_PRESENT = 2'd2,
		ST_ABSENT  = 2'd3
	} status_t;

	typedef struct packed {
		logic               req_type;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic        [1:0]  status;
		logic        [7:0]  member_count;
		logic signed [31:0] largest_member;
		logic               set_empty;
	} rsp_t;

	// Classified request as held in the queue between front and back
	typedef struct packed {
		req_kind_t          kind;
		logic signed [31:0] value;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_DONE
	} back_state_t;

endpackage

// File: rtl/core/bis_ram.sv
// ----------------------------------------------------------------------------
// bis_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bis_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/bis_front.sv
// ----------------------------------------------------------------------------
// bis_front
// Request intake: classify each beat and hold it in a two-entry queue.
// ----------------------------------------------------------------------------
module bis_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  bis_pkg::req_t req,
	output logic          cmd_valid,
	output bis_pkg::cmd_t cmd,
	input  logic          cmd_pop
);

	bis_pkg::cmd_t q_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    fill_q;
	logic          push;
	logic          pop;
	bis_pkg::cmd_t cmd_in;

	// Classify: decode the request code into an operation
	always_comb begin
		cmd_in.value = req.value;
		unique case (req.req_type)
			1'b0:    cmd_in.kind = bis_pkg::REQ_INSERT;
			default: cmd_in.kind = bis_pkg::REQ_REMOVE;
		endcase
	end

	assign req_stall = (fill_q == 2'd2);
	assign push      = req_valid && !req_stall;
	assign cmd_valid = (fill_q != 2'd0);
	assign pop       = cmd_pop && cmd_valid;
	assign cmd       = q_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// File: rtl/core/bis_back.sv
// ----------------------------------------------------------------------------
// bis_back
// Request execution: one scan over the stored members per request, doing
// the match search, the compaction shift and the maximum in the same pass.
// ----------------------------------------------------------------------------
module bis_back #(
	parameter int CAPACITY = bis_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  bis_pkg::cmd_t cmd,
	output logic          cmd_pop,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output bis_pkg::rsp_t rsp
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	bis_pkg::back_state_t state_q, state_d;

	bis_pkg::req_kind_t kind_q;
	logic signed [31:0] val_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      iss_q;
	logic               dv_s1;
	logic [AW-1:0]      di_s1;
	logic               found_q;
	logic               have_max_q;
	logic signed [31:0] max_q;
	logic               rsp_valid_q;
	bis_pkg::rsp_t      rsp_q;

	logic               rd_en;
	logic signed [31:0] rdata;
	logic               eq;
	logic               last;
	logic               max_upd;
	logic               we;
	logic [AW-1:0]      waddr;
	logic [31:0]        wdata;
	logic               fire;
	logic               full;
	logic               ins_ok;
	logic               rem_ok;
	logic [CW-1:0]      new_count;
	logic [1:0]         status;
	logic signed [31:0] final_max;

	bis_ram #(
		.WIDTH(32),
		.DEPTH(CAPACITY)
	) u_mem (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(iss_q[AW-1:0]),
		.rdata(rdata)
	);

	assign rd_en = (state_q == bis_pkg::BK_SCAN) && (iss_q < count_q);
	assign eq    = (rdata == val_q);
	assign last  = dv_s1 && (CW'(di_s1) == count_q - CW'(1));

	// A removed match drops out of the maximum; on insert every member counts
	assign max_upd = (state_q == bis_pkg::BK_SCAN) && dv_s1
			&& !(eq && (kind_q == bis_pkg::REQ_REMOVE))
			&& (!have_max_q || (rdata > max_q));

	assign full   = (kind_q == bis_pkg::REQ_INSERT) && (count_q >= CW'(CAPACITY));
	assign ins_ok = (kind_q == bis_pkg::REQ_INSERT) && !full && !found_q;
	assign rem_ok = (kind_q == bis_pkg::REQ_REMOVE) && found_q;
	assign fire   = (state_q == bis_pkg::BK_DONE) && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		if (full) begin
			status = bis_pkg::ST_FULL;
		end else if (kind_q == bis_pkg::REQ_INSERT) begin
			status = found_q ? bis_pkg::ST_PRESENT : bis_pkg::ST_OK;
		end else begin
			status = found_q ? bis_pkg::ST_OK : bis_pkg::ST_ABSENT;
		end

		if (ins_ok) begin
			new_count = count_q + CW'(1);
		end else if (rem_ok) begin
			new_count = count_q - CW'(1);
		end else begin
			new_count = count_q;
		end

		if (new_count == '0) begin
			final_max = '0;
		end else if (ins_ok && (!have_max_q || (val_q > max_q))) begin
			final_max = val_q;
		end else begin
			final_max = max_q;
		end
	end

	// Write port: shift down behind a removed match, or append on insert
	always_comb begin
		we    = 1'b0;
		waddr = di_s1 - AW'(1);
		wdata = rdata;
		if (state_q == bis_pkg::BK_SCAN) begin
			we = dv_s1 && !eq && found_q && (kind_q == bis_pkg::REQ_REMOVE);
		end else if (fire && ins_ok) begin
			we    = 1'b1;
			waddr = count_q[AW-1:0];
			wdata = val_q;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd_pop = 1'b0;
		unique case (state_q)
			bis_pkg::BK_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					state_d = (count_q == '0) ? bis_pkg::BK_DONE : bis_pkg::BK_SCAN;
				end
			end
			bis_pkg::BK_SCAN: begin
				if (last) begin
					state_d = bis_pkg::BK_DONE;
				end
			end
			bis_pkg::BK_DONE: begin
				if (fire) begin
					state_d = bis_pkg::BK_IDLE;
				end
			end
			default: state_d = bis_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bis_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			iss_q       <= '0;
			dv_s1       <= 1'b0;
			found_q     <= 1'b0;
			have_max_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			dv_s1 <= rd_en;
			if (cmd_pop) begin
				iss_q      <= '0;
				found_q    <= 1'b0;
				have_max_q <= 1'b0;
			end else if (rd_en) begin
				iss_q <= iss_q + CW'(1);
			end
			if ((state_q == bis_pkg::BK_SCAN) && dv_s1 && eq) begin
				found_q <= 1'b1;
			end
			if (max_upd) begin
				have_max_q <= 1'b1;
			end
			if (fire) begin
				count_q     <= new_count;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		di_s1 <= iss_q[AW-1:0];
		if (cmd_pop) begin
			kind_q <= cmd.kind;
			val_q  <= cmd.value;
		end
		if (max_upd) begin
			max_q <= rdata;
		end
		if (fire) begin
			rsp_q.status         <= status;
			rsp_q.member_count   <= 8'(new_count);
			rsp_q.largest_member <= final_max;
			rsp_q.set_empty      <= (new_count == '0);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: rtl/core/bounded_integer_set_store.sv
// ----------------------------------------------------------------------------
// bounded_integer_set_store
// Set of distinct signed 32-bit integers with insert and remove requests.
// ----------------------------------------------------------------------------
// Each request beat on req asks to insert (req_type 0) or remove (req_type 1)
// one value, and yields exactly one beat on rsp carrying a status (ok, set
// full, already present, not found), the member count after the request, the
// largest member (0 when empty) and an empty flag. Members live in arrival
// order in a single-port-write, single-port-read RAM; a remove closes the gap
// by shifting later members down one place. Every request walks the stored
// members once, one RAM read per cycle, finding the match, moving entries and
// tracking the maximum in the same pass; a request on an empty set skips the
// walk. A two-entry request queue lets the sender run ahead while a request
// executes, and a registered response lets the next request start while the
// previous answer still waits to be taken. member_count carries the low eight
// bits of the count. Requests are served strictly in order.
// ----------------------------------------------------------------------------
module bounded_integer_set_store #(
	parameter int CAPACITY = bis_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  bis_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output bis_pkg::rsp_t rsp
);

	// Queue between intake and execution
	logic          cmd_valid;
	bis_pkg::cmd_t cmd;
	logic          cmd_pop;

	// Accept and classify request beats; hold up to two ahead of execution
	bis_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop)
	);

	// Execute one request at a time against the member store
	bis_back #(
		.CAPACITY(CAPACITY)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule
